FILE: hdl/hitv_pkg.sv
// Shared types and constants of the hashed identifier table with match vote.
package hitv_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_MARK  = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} bsel_t;

	typedef struct packed {
		logic  capture;
		logic  mark;
		logic  cand_inc;
		logic  push;
		bsel_t bsel;
		logic  comp_start;
		logic  round;
		logic  comp_add;
		logic  final_word;
		logic  set_dup;
		logic  store;
		logic  walk_rd;
		logic  walk_dec;
		logic  scan_init;
		logic  scan_rd;
		logic  scan_cmp;
		logic  out_load_add;
		logic  out_load_chk;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic [5:0] pos;
		logic       rnd_last;
		logic       full;
		logic       walk_more;
		logic       scan_more;
		logic       rd_eq;
		logic       type_diff;
	} stat_t;

endpackage

FILE: hdl/hitv_in_if.sv
// Input item channel of the hashed identifier table.
interface hitv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  data_byte;
	logic [1:0]  block_type;
	logic [31:0] candidate_word;
	logic        last;

	modport source (output valid, opcode, data_byte, block_type, candidate_word, last,
		input ready);
	modport sink (input valid, opcode, data_byte, block_type, candidate_word, last,
		output ready);
endinterface

FILE: hdl/hitv_out_if.sv
// Result item channel of the hashed identifier table.
interface hitv_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [1:0]  add_status;
	logic [31:0] entry_word;
	logic [5:0]  entry_index;
	logic        verdict;
	logic [2:0]  types_equal;
	logic [2:0]  types_present;

	modport source (output valid, result_kind, add_status, entry_word, entry_index, verdict,
		types_equal, types_present, input ready);
	modport sink (input valid, result_kind, add_status, entry_word, entry_index, verdict,
		types_equal, types_present, output ready);
endinterface

FILE: hdl/hitv_dp.sv
// Datapath: SHA-1 engine, entry table memory, duplicate walk and match vote.
module hitv_dp #(
	parameter int TABLE_DEPTH = hitv_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hitv_pkg::cmd_t      cmd,
	output hitv_pkg::stat_t     stat,
	input  logic [1:0]          opcode,
	input  logic [7:0]          data_byte,
	input  logic [1:0]          block_type,
	input  logic [31:0]         candidate_word,
	input  logic                last,
	output logic                result_kind,
	output logic [1:0]          add_status,
	output logic [31:0]         entry_word,
	output logic [5:0]          entry_index,
	output logic                verdict,
	output logic [2:0]          types_equal,
	output logic [2:0]          types_present
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(TABLE_DEPTH + 2);

	function automatic logic [2:0] cnt4(input logic [3:0] v);
		return {2'b0, v[0]} + {2'b0, v[1]} + {2'b0, v[2]} + {2'b0, v[3]};
	endfunction

	logic [1:0]   op_q;
	logic [7:0]   byte_q;
	logic [1:0]   type_q;
	logic [31:0]  cand_q;
	logic         last_q;
	logic [511:0] blk_q;
	logic [5:0]   pos_q;
	logic [31:0]  len_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [31:0]  word_q;
	logic [1:0]   status_q;
	logic [CW-1:0] index_q, count_q, start_q, idx_q;
	logic [31:0]  rd_q;
	logic [3:0]   present_q, eqf_q;
	logic [NW-1:0] ncand_q;
	logic [31:0]  mem [TABLE_DEPTH];

	logic [7:0]   push_byte;
	logic [63:0]  len_bits;
	logic [31:0]  w_new, f_v, k_v, t_v;
	logic [2:0]   neq, npres;

	assign len_bits = {29'b0, len_q, 3'b0};

	always_comb begin
		case (cmd.bsel)
			hitv_pkg::BSEL_DATA: push_byte = byte_q;
			hitv_pkg::BSEL_PAD:  push_byte = 8'h80;
			hitv_pkg::BSEL_LEN:  push_byte = 8'(len_bits >> {3'd7 - pos_q[2:0], 3'b0});
			default:             push_byte = 8'h00;
		endcase
	end

	assign w_new = {blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64]};

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_v = (b_q & c_q) | (~b_q & d_q);
			k_v = hitv_pkg::K_R0;
		end else if (rnd_q < 7'd40) begin
			f_v = b_q ^ c_q ^ d_q;
			k_v = hitv_pkg::K_R1;
		end else if (rnd_q < 7'd60) begin
			f_v = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_v = hitv_pkg::K_R2;
		end else begin
			f_v = b_q ^ c_q ^ d_q;
			k_v = hitv_pkg::K_R3;
		end
	end

	assign t_v = {a_q[26:0], a_q[31:27]} + f_v + e_q + k_v + blk_q[511:480];

	assign neq   = cnt4(eqf_q);
	assign npres = cnt4(present_q);

	always_comb begin
		stat.op        = op_q;
		stat.last      = last_q;
		stat.pos       = pos_q;
		stat.rnd_last  = (rnd_q == hitv_pkg::LAST_ROUND);
		stat.full      = (count_q >= CW'(TABLE_DEPTH));
		stat.walk_more = (idx_q > start_q);
		stat.scan_more = (idx_q < count_q);
		stat.rd_eq     = (rd_q == word_q);
		stat.type_diff = (rd_q[1:0] != word_q[1:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			byte_q <= data_byte;
			type_q <= block_type;
			cand_q <= candidate_word;
			last_q <= last;
		end
		if (cmd.push) begin
			blk_q <= {blk_q[503:0], push_byte};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new[30:0], w_new[31]};
		end
		if (cmd.comp_start) begin
			a_q   <= h_q[0];
			b_q   <= h_q[1];
			c_q   <= h_q[2];
			d_q   <= h_q[3];
			e_q   <= h_q[4];
			rnd_q <= '0;
		end else if (cmd.round) begin
			a_q   <= t_v;
			b_q   <= a_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			d_q   <= c_q;
			e_q   <= d_q;
			rnd_q <= rnd_q + 7'd1;
		end
		if (cmd.walk_rd) begin
			rd_q <= mem[AW'(idx_q - CW'(1))];
		end else if (cmd.scan_rd) begin
			rd_q <= mem[AW'(idx_q)];
		end
		if (cmd.store) begin
			mem[AW'(count_q)] <= word_q;
		end
		if (cmd.final_word) begin
			word_q   <= {h_q[0][31:2], type_q};
			index_q  <= count_q;
			status_q <= stat.full ? hitv_pkg::ST_FULL : hitv_pkg::ST_STORED;
		end else if (cmd.set_dup) begin
			status_q <= hitv_pkg::ST_DUP;
		end
		if (cmd.out_load_add) begin
			result_kind   <= hitv_pkg::KIND_ADD;
			add_status    <= status_q;
			entry_word    <= word_q;
			entry_index   <= 6'(index_q);
			verdict       <= 1'b0;
			types_equal   <= '0;
			types_present <= '0;
		end else if (cmd.out_load_chk) begin
			result_kind   <= hitv_pkg::KIND_CHECK;
			add_status    <= '0;
			entry_word    <= '0;
			entry_index   <= '0;
			verdict       <= eqf_q[0] && (neq == npres || neq >= 3'd3) &&
				(ncand_q <= NW'(TABLE_DEPTH));
			types_equal   <= neq;
			types_present <= npres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			h_q       <= hitv_pkg::H_INIT;
			count_q   <= '0;
			start_q   <= '0;
			idx_q     <= '0;
			present_q <= '0;
			eqf_q     <= '0;
			ncand_q   <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
				if (cmd.bsel == hitv_pkg::BSEL_DATA) begin
					len_q <= len_q + 32'd1;
				end
			end
			if (cmd.comp_add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.final_word) begin
				h_q   <= hitv_pkg::H_INIT;
				len_q <= '0;
				pos_q <= '0;
				idx_q <= count_q;
			end
			if (cmd.mark) begin
				start_q <= count_q;
			end
			if (cmd.store) begin
				count_q   <= count_q + CW'(1);
				present_q <= present_q | (4'b1 << word_q[1:0]);
			end
			if (cmd.walk_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.scan_init) begin
				idx_q <= '0;
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.cand_inc && ncand_q <= NW'(TABLE_DEPTH)) begin
				ncand_q <= ncand_q + NW'(1);
			end
			if (cmd.scan_cmp && rd_q == cand_q) begin
				eqf_q <= eqf_q | (4'b1 << rd_q[1:0]);
			end
			if (cmd.out_load_chk) begin
				eqf_q   <= '0;
				ncand_q <= '0;
			end
		end
	end
endmodule

FILE: hdl/hitv_ctrl.sv
// Controller state machine that sequences hashing, table walks and result delivery.
module hitv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_opcode,
	output logic            out_valid,
	input  logic            out_ready,
	input  hitv_pkg::stat_t stat,
	output hitv_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_PAD80,
		S_ZERO,
		S_LEN,
		S_ROUND,
		S_CADD,
		S_FINAL,
		S_WALK_RD,
		S_WALK_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_RESULT
	} state_t;

	state_t state_q, state_n, ret_q, ret_n;
	logic   load;
	logic   blk_end;

	assign blk_end  = (stat.pos == hitv_pkg::LAST_POS);
	assign in_ready = (state_q == S_IDLE);
	assign load     = (state_q == S_RESULT) && (!out_valid || out_ready);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		ret_n   = ret_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_opcode)
						hitv_pkg::OP_ADD: state_n = S_PUSH;
						hitv_pkg::OP_CHECK: begin
							cmd.cand_inc  = 1'b1;
							cmd.scan_init = 1'b1;
							state_n       = S_SCAN_RD;
						end
						hitv_pkg::OP_MARK: cmd.mark = 1'b1;
						default: ;
					endcase
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				cmd.bsel = hitv_pkg::BSEL_DATA;
				if (blk_end) begin
					cmd.comp_start = 1'b1;
					ret_n          = stat.last ? S_PAD80 : S_IDLE;
					state_n        = S_ROUND;
				end else begin
					state_n = stat.last ? S_PAD80 : S_IDLE;
				end
			end
			S_PAD80: begin
				cmd.push = 1'b1;
				cmd.bsel = hitv_pkg::BSEL_PAD;
				if (blk_end) begin
					cmd.comp_start = 1'b1;
					ret_n          = S_ZERO;
					state_n        = S_ROUND;
				end else begin
					state_n = S_ZERO;
				end
			end
			S_ZERO: begin
				if (stat.pos == hitv_pkg::LEN_POS) begin
					state_n = S_LEN;
				end else begin
					cmd.push = 1'b1;
					cmd.bsel = hitv_pkg::BSEL_ZERO;
					if (blk_end) begin
						cmd.comp_start = 1'b1;
						ret_n          = S_ZERO;
						state_n        = S_ROUND;
					end
				end
			end
			S_LEN: begin
				cmd.push = 1'b1;
				cmd.bsel = hitv_pkg::BSEL_LEN;
				if (blk_end) begin
					cmd.comp_start = 1'b1;
					ret_n          = S_FINAL;
					state_n        = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (stat.rnd_last) begin
					state_n = S_CADD;
				end
			end
			S_CADD: begin
				cmd.comp_add = 1'b1;
				state_n      = ret_q;
			end
			S_FINAL: begin
				cmd.final_word = 1'b1;
				state_n        = stat.full ? S_RESULT : S_WALK_RD;
			end
			S_WALK_RD: begin
				if (stat.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_n     = S_WALK_CMP;
				end else begin
					cmd.store = 1'b1;
					state_n   = S_RESULT;
				end
			end
			S_WALK_CMP: begin
				if (stat.rd_eq) begin
					cmd.set_dup = 1'b1;
					state_n     = S_RESULT;
				end else if (stat.type_diff) begin
					cmd.store = 1'b1;
					state_n   = S_RESULT;
				end else begin
					cmd.walk_dec = 1'b1;
					state_n      = S_WALK_RD;
				end
			end
			S_SCAN_RD: begin
				if (stat.scan_more) begin
					cmd.scan_rd = 1'b1;
					state_n     = S_SCAN_CMP;
				end else begin
					state_n = stat.last ? S_RESULT : S_IDLE;
				end
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_n      = S_SCAN_RD;
			end
			S_RESULT: begin
				if (load) begin
					cmd.out_load_add = (stat.op == hitv_pkg::OP_ADD);
					cmd.out_load_chk = (stat.op != hitv_pkg::OP_ADD);
					state_n          = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

FILE: hdl/hashed_id_table_with_match_vote_unit.sv
// Top level of the hashed identifier table with match vote.
// Items arrive on item_ch (valid/ready). Opcode add streams message bytes into a
// SHA-1 engine; the item marked last finishes the hash and gives one add result.
// Opcode check streams candidate words; the word marked last gives one verdict.
// Opcode mark moves the start of the duplicate walk to the current entry count.
// Results leave on result_ch through an output register.
// The block works on one item at a time. A non-final add byte is pushed into the
// message block; when it completes a 64-byte block, the 80 SHA-1 rounds run first,
// one per cycle. A final add byte is followed by the padding bytes, one per cycle
// while no compression runs, one or two compressions, then the duplicate walk that
// reads and compares one entry at a time. A check word reads and compares each
// stored entry in turn through the single read port of the entry table memory.
// Reset empties the table, clears the start mark and the vote and restarts the
// hash. The table needs no clearing pass. When the receiver stalls, the block
// keeps taking items until it has a second result to hand over, and then waits.
module hashed_id_table_with_match_vote_unit #(
	parameter int TABLE_DEPTH = hitv_pkg::TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hitv_in_if.sink   item_ch,
	hitv_out_if.source result_ch
);
	hitv_pkg::cmd_t  cmd;
	hitv_pkg::stat_t stat;

	hitv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_ch.valid),
		.in_ready  (item_ch.ready),
		.in_opcode (item_ch.opcode),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hitv_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (item_ch.opcode),
		.data_byte      (item_ch.data_byte),
		.block_type     (item_ch.block_type),
		.candidate_word (item_ch.candidate_word),
		.last           (item_ch.last),
		.result_kind    (result_ch.result_kind),
		.add_status     (result_ch.add_status),
		.entry_word     (result_ch.entry_word),
		.entry_index    (result_ch.entry_index),
		.verdict        (result_ch.verdict),
		.types_equal    (result_ch.types_equal),
		.types_present  (result_ch.types_present)
	);
endmodule

FILE: tb/sv/hashed_id_table_with_match_vote_unit_tb.sv
// Self-checking testbench: directed and random items checked against a SHA-1 table predictor.
`timescale 1ns / 100ps
module hashed_id_table_with_match_vote_unit_tb;

	localparam int DEPTH = hitv_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [31:0] word;
		logic [5:0]  index;
		logic        verdict;
		logic [2:0]  n_equal;
		logic [2:0]  n_present;
	} result_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [1:0]  btype;
		logic [31:0] cand;
		logic        last;
		int          slot;
		bit          typed;
		result_t     want;
	} row_t;

	logic clk;
	logic arst_n;
	hitv_in_if  item_ch ();
	hitv_out_if result_ch ();

	hashed_id_table_with_match_vote_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .item_ch(item_ch), .result_ch(result_ch)
	);

	bit [31:0] ids [DEPTH];
	int unsigned id_count, mark_index, msg_len, vote_words;
	bit [31:0] chain [5];
	bit [7:0] msg_buf [64];
	bit [3:0] equal_types;

	result_t pending [$];
	int cycle_count, mismatches, items_sent, quiet_lo, quiet_hi;

	function automatic bit [31:0] rol(bit [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha1_block(ref bit [31:0] h [5], input bit [7:0] blk [64]);
		bit [31:0] w [80];
		bit [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = hitv_pkg::K_R0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = hitv_pkg::K_R1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = hitv_pkg::K_R2;
			end else begin
				f = b ^ c ^ d; k = hitv_pkg::K_R3;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endfunction

	function automatic bit [31:0] digest_h0();
		bit [31:0] h [5];
		bit [7:0] blk [64];
		int r;
		bit [63:0] bits;
		r = msg_len & 63;
		bits = 64'(msg_len) * 8;
		h = chain;
		for (int i = 0; i < 64; i++)
			blk[i] = (i < r) ? msg_buf[i] : 8'h00;
		blk[r] = 8'h80;
		if (r >= 56) begin
			sha1_block(h, blk);
			for (int i = 0; i < 64; i++)
				blk[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk[63-i] = bits[8*i +: 8];
		sha1_block(h, blk);
		return h[0];
	endfunction

	function automatic void table_reset();
		id_count = 0; mark_index = 0; msg_len = 0; equal_types = 0; vote_words = 0;
		for (int i = 0; i < 5; i++)
			chain[i] = hitv_pkg::H_INIT[i];
	endfunction

	function automatic bit table_step(logic [1:0] op, logic [7:0] data, logic [1:0] btype,
			logic [31:0] cand, logic last, output result_t res);
		bit [31:0] word;
		bit [3:0] present;
		int n_eq, n_pr;
		res = '0;
		if (op == hitv_pkg::OP_ADD) begin
			msg_buf[msg_len & 63] = data;
			msg_len++;
			if ((msg_len & 63) == 0)
				sha1_block(chain, msg_buf);
			if (!last)
				return 0;
			word = digest_h0();
			word[1:0] = btype;
			for (int i = 0; i < 5; i++)
				chain[i] = hitv_pkg::H_INIT[i];
			msg_len = 0;
			res.kind = hitv_pkg::KIND_ADD;
			res.status = hitv_pkg::ST_STORED;
			res.word = word;
			res.index = 6'(id_count);
			if (id_count >= DEPTH) begin
				res.status = hitv_pkg::ST_FULL;
			end else begin
				for (int i = id_count; i > mark_index; i--) begin
					if (ids[i-1] == word) begin
						res.status = hitv_pkg::ST_DUP;
						break;
					end
					if (ids[i-1][1:0] != word[1:0])
						break;
				end
				if (res.status == hitv_pkg::ST_STORED) begin
					ids[id_count] = word;
					id_count++;
				end
			end
			return 1;
		end
		if (op == hitv_pkg::OP_CHECK) begin
			if (vote_words <= DEPTH)
				vote_words++;
			for (int i = 0; i < id_count; i++)
				if (ids[i] == cand)
					equal_types[ids[i][1:0]] = 1'b1;
			if (!last)
				return 0;
			present = 0;
			for (int i = 0; i < id_count; i++)
				present[ids[i][1:0]] = 1'b1;
			n_eq = $countones(equal_types);
			n_pr = $countones(present);
			res.kind = hitv_pkg::KIND_CHECK;
			res.verdict = equal_types[0] && (n_eq == n_pr || n_eq >= 3) && vote_words <= DEPTH;
			res.n_equal = 3'(n_eq);
			res.n_present = 3'(n_pr);
			equal_types = 0;
			vote_words = 0;
			return 1;
		end
		if (op == hitv_pkg::OP_MARK)
			mark_index = id_count;
		return 0;
	endfunction

	function automatic bit take_break();
		return (cycle_count < quiet_lo || cycle_count > quiet_hi) && $urandom_range(99) < 10;
	endfunction

	task automatic send(logic [1:0] op, logic [7:0] data, logic [1:0] btype, logic [31:0] cand,
			logic last, int slot = -1, bit typed = 0, result_t want = '0);
		result_t res;
		@(negedge clk);
		while (take_break()) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		if (slot >= 0 && id_count > 0)
			cand = ids[slot % id_count];
		item_ch.valid = 1'b1;
		item_ch.opcode = op;
		item_ch.data_byte = data;
		item_ch.block_type = btype;
		item_ch.candidate_word = cand;
		item_ch.last = last;
		forever begin
			@(posedge clk);
			if (item_ch.ready)
				break;
		end
		if (table_step(op, data, btype, cand, last, res))
			pending.push_back(typed ? want : res);
		items_sent++;
	endtask

	task automatic send_message();
		int len;
		logic [1:0] btype;
		len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(50, 130);
		btype = 2'($urandom_range(3));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 3)
				send(hitv_pkg::OP_MARK, 8'($urandom), 2'($urandom), $urandom, 1'($urandom));
			else if ($urandom_range(99) < 3)
				send(hitv_pkg::OP_CHECK, 8'($urandom), 2'($urandom), $urandom, 1'b0);
			send(hitv_pkg::OP_ADD, 8'($urandom), (i == len - 1) ? btype : 2'($urandom),
				$urandom, i == len - 1);
		end
	endtask

	task automatic send_check();
		int n;
		n = ($urandom_range(99) < 95) ? $urandom_range(1, 6) : $urandom_range(30, 36);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 75)
				send(hitv_pkg::OP_CHECK, 8'($urandom), 2'($urandom), $urandom, i == n - 1,
					int'($urandom_range(63)));
			else
				send(hitv_pkg::OP_CHECK, 8'($urandom), 2'($urandom), $urandom, i == n - 1);
			if ($urandom_range(99) < 3)
				send(hitv_pkg::OP_ADD, 8'($urandom), 2'($urandom), $urandom, 1'b0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		result_ch.ready <= !take_break();

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.result_kind, result_ch.add_status, result_ch.entry_word,
				result_ch.entry_index, result_ch.verdict, result_ch.types_equal,
				result_ch.types_present};
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		int r;
		bit paused;
		cycle_count = 0;
		mismatches = 0;
		items_sent = 0;
		paused = 1'b0;
		quiet_lo = $urandom_range(5000, 15000);
		quiet_hi = quiet_lo + 8000;
		item_ch.valid = 1'b0;
		item_ch.opcode = hitv_pkg::OP_ADD;
		item_ch.data_byte = '0;
		item_ch.block_type = '0;
		item_ch.candidate_word = '0;
		item_ch.last = 1'b0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		table_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b1, -1, 1,
				'{hitv_pkg::KIND_CHECK, 2'd0, 32'h0, 6'd0, 1'b0, 3'd0, 3'd0}},
			'{hitv_pkg::OP_ADD, 8'h00, 2'd0, 32'h0, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'h00, 2'd0, 32'h0, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'hFF, 2'd3, 32'hFFFFFFFF, 1'b0, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'hFF, 2'd3, 32'hFFFFFFFF, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_SPARE, 8'hFF, 2'd3, 32'hFFFFFFFF, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_MARK, 8'h00, 2'd0, 32'h0, 1'b0, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'h00, 2'd0, 32'h0, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'h5A, 2'd1, 32'h0, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_ADD, 8'hA5, 2'd2, 32'h0, 1'b1, -1, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b0, 0, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b0, 1, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b0, 3, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b1, 4, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'h00, 2'd0, 32'h0, 1'b1, 0, 0, '0},
			'{hitv_pkg::OP_CHECK, 8'hFF, 2'd3, 32'hFFFFFFFF, 1'b1, -1, 0, '0}
		};
		foreach (rows[i])
			send(rows[i].op, rows[i].data, rows[i].btype, rows[i].cand, rows[i].last,
				rows[i].slot, rows[i].typed, rows[i].want);

		while (items_sent < 1150) begin
			if (!paused && items_sent > 600) begin
				paused = 1'b1;
				@(negedge clk);
				item_ch.valid = 1'b0;
				while (pending.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(99);
			if (r < 50)
				send_message();
			else if (r < 85)
				send_check();
			else if (r < 93)
				send(hitv_pkg::OP_MARK, 8'($urandom), 2'($urandom), $urandom, 1'($urandom));
			else
				send(hitv_pkg::OP_SPARE, 8'($urandom), 2'($urandom), $urandom, 1'($urandom));
		end
		@(negedge clk);
		item_ch.valid = 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/hitv_pkg.sv
hdl/hitv_in_if.sv
hdl/hitv_out_if.sv
hdl/hitv_dp.sv
hdl/hitv_ctrl.sv
hdl/hashed_id_table_with_match_vote_unit.sv
tb/sv/hashed_id_table_with_match_vote_unit_tb.sv
